// ===== hw/rtl/tssm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared constants and types for the two-stack shared memory block.
// ----------------------------------------------------------------------------
package tssm_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
	localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);

	localparam logic [1:0] REQ_PUSH_LOW  = 2'd0;
	localparam logic [1:0] REQ_PUSH_HIGH = 2'd1;
	localparam logic [1:0] REQ_POP_LOW   = 2'd2;
	localparam logic [1:0] REQ_POP_HIGH  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [1:0] ST_UNDERFLOW = 2'd2;

	typedef struct packed {
		logic load;   // take the request in this cycle
	} ctl_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tssm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_req_if
// Request channel: stack operation code and word to push.
// ----------------------------------------------------------------------------
interface tssm_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          req_type;
	logic signed [tssm_pkg::WORD_W-1:0]  push_value;

	modport source (output valid, output req_type, output push_value, input ready);
	modport sink   (input valid, input req_type, input push_value, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tssm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_rsp_if
// Response channel: popped word and status code.
// ----------------------------------------------------------------------------
interface tssm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [tssm_pkg::WORD_W-1:0]  pop_value;
	logic [1:0]                          status;

	modport source (output valid, output pop_value, output status, input ready);
	modport sink   (input valid, input pop_value, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/tssm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_ctrl
// Handshake controller: tracks whether a result is waiting and issues loads.
// ----------------------------------------------------------------------------
module tssm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tssm_pkg::ctl_cmd_t     cmd
);

	localparam logic S_EMPTY = 1'b0;
	localparam logic S_FULL  = 1'b1;

	logic state_q;
	logic state_d;

	// a new request may enter while the old result leaves
	assign in_ready  = (state_q == S_EMPTY) || out_ready;
	assign out_valid = (state_q == S_FULL);
	assign cmd.load  = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_EMPTY: begin
				if (cmd.load) state_d = S_FULL;
			end
			S_FULL: begin
				if (cmd.load) state_d = S_FULL;
				else if (out_ready) state_d = S_EMPTY;
			end
			default: state_d = S_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tssm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tssm_datapath
// Shared word memory, the two stack counts and the result register.
// ----------------------------------------------------------------------------
module tssm_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire tssm_pkg::ctl_cmd_t                  cmd,
	input  wire logic [1:0]                          req_type,
	input  wire logic signed [tssm_pkg::WORD_W-1:0]  push_value,
	output logic signed [tssm_pkg::WORD_W-1:0]       pop_value,
	output logic [1:0]                               status
);

	logic [tssm_pkg::WORD_W-1:0] mem [tssm_pkg::DEPTH];

	logic [tssm_pkg::CNT_W-1:0]  cnt_low_q;
	logic [tssm_pkg::CNT_W-1:0]  cnt_high_q;
	logic [tssm_pkg::CNT_W-1:0]  cnt_low_d;
	logic [tssm_pkg::CNT_W-1:0]  cnt_high_d;
	logic [tssm_pkg::WORD_W-1:0] rdata_q;
	logic [1:0]                  status_q;
	logic                        pop_ok_q;

	logic [tssm_pkg::CNT_W:0]    used;
	logic                        has_free;
	logic [tssm_pkg::CNT_W-1:0]  low_dec;
	logic [tssm_pkg::CNT_W-1:0]  high_push_pos;
	logic [tssm_pkg::CNT_W-1:0]  high_pop_pos;
	logic                        wr_en;
	logic                        rd_en;
	logic [tssm_pkg::ADDR_W-1:0] wr_addr;
	logic [tssm_pkg::ADDR_W-1:0] rd_addr;
	logic [1:0]                  status_d;

	assign used          = {1'b0, cnt_low_q} + {1'b0, cnt_high_q};
	assign has_free      = used < tssm_pkg::DEPTH_SUM;
	assign low_dec       = cnt_low_q - tssm_pkg::CNT_W'(1);
	assign high_push_pos = tssm_pkg::DEPTH_C - cnt_high_q - tssm_pkg::CNT_W'(1);
	assign high_pop_pos  = tssm_pkg::DEPTH_C - cnt_high_q;

	always_comb begin
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		wr_addr    = cnt_low_q[tssm_pkg::ADDR_W-1:0];
		rd_addr    = low_dec[tssm_pkg::ADDR_W-1:0];
		cnt_low_d  = cnt_low_q;
		cnt_high_d = cnt_high_q;
		status_d   = tssm_pkg::ST_OK;
		unique case (req_type)
			tssm_pkg::REQ_PUSH_LOW: begin
				if (has_free) begin
					wr_en     = 1'b1;
					cnt_low_d = cnt_low_q + tssm_pkg::CNT_W'(1);
				end else begin
					status_d = tssm_pkg::ST_OVERFLOW;
				end
			end
			tssm_pkg::REQ_PUSH_HIGH: begin
				wr_addr = high_push_pos[tssm_pkg::ADDR_W-1:0];
				if (has_free) begin
					wr_en      = 1'b1;
					cnt_high_d = cnt_high_q + tssm_pkg::CNT_W'(1);
				end else begin
					status_d = tssm_pkg::ST_OVERFLOW;
				end
			end
			tssm_pkg::REQ_POP_LOW: begin
				if (cnt_low_q != '0) begin
					rd_en     = 1'b1;
					cnt_low_d = low_dec;
				end else begin
					status_d = tssm_pkg::ST_UNDERFLOW;
				end
			end
			tssm_pkg::REQ_POP_HIGH: begin
				rd_addr = high_pop_pos[tssm_pkg::ADDR_W-1:0];
				if (cnt_high_q != '0) begin
					rd_en      = 1'b1;
					cnt_high_d = cnt_high_q - tssm_pkg::CNT_W'(1);
				end else begin
					status_d = tssm_pkg::ST_UNDERFLOW;
				end
			end
			default: status_d = tssm_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_en) begin
			mem[wr_addr] <= push_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_low_q  <= '0;
			cnt_high_q <= '0;
			status_q   <= tssm_pkg::ST_OK;
			pop_ok_q   <= 1'b0;
		end else if (cmd.load) begin
			cnt_low_q  <= cnt_low_d;
			cnt_high_q <= cnt_high_d;
			status_q   <= status_d;
			pop_ok_q   <= rd_en;
		end
	end

	// underflow answers all ones, a push answers zero
	always_comb begin
		if (status_q == tssm_pkg::ST_UNDERFLOW) begin
			pop_value = '1;
		end else if (pop_ok_q) begin
			pop_value = rdata_q;
		end else begin
			pop_value = '0;
		end
	end

	assign status = status_q;

endmodule
`default_nettype wire

// ===== hw/rtl/two_stacks_shared_memory.sv =====
`timescale 1ns / 1ps
`default_nettype none
// a result is registered and offered in the cycle after its request transfer
// throughput: one request per cycle while results are taken as offered
// the result register holds while the sink stalls; the request side waits then
// reset clears the stack counts and status flags but not the read data; memory
// words stay undefined until pushed, and are never read before that
// ----------------------------------------------------------------------------
// two_stacks_shared_memory
// Two LIFO stacks in one word memory, one growing up and one growing down.
// ----------------------------------------------------------------------------
module two_stacks_shared_memory (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tssm_req_if.sink    req,
	tssm_rsp_if.source  rsp
);

	tssm_pkg::ctl_cmd_t cmd;

	tssm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	tssm_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req.req_type),
		.push_value (req.push_value),
		.pop_value  (rsp.pop_value),
		.status     (rsp.status)
	);

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the two-stack shared memory against a scoreboard model of both
// stacks: directed empty, extreme-word and full-memory cases, then bursts of
// push-heavy and pop-heavy traffic under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned TRAFFIC_ITEMS = 380;

	typedef struct packed {
		logic [tssm_pkg::WORD_W-1:0] word;
		logic [1:0]                  code;
	} stack_answer_t;

	logic clk;
	logic arst_n;

	tssm_req_if req_ch ();
	tssm_rsp_if rsp_ch ();

	two_stacks_shared_memory dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// scoreboard copy of the shared store and both stack heights
	logic [tssm_pkg::WORD_W-1:0] stored_words [tssm_pkg::DEPTH];
	int unsigned                 low_count;
	int unsigned                 high_count;
	stack_answer_t               pending_answers [$];

	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	int unsigned fail_count;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic stack_answer_t predict_answer(input logic [1:0] kind,
			input logic [tssm_pkg::WORD_W-1:0] value);
		stack_answer_t ans;
		ans.word = '0;
		ans.code = tssm_pkg::ST_OK;
		case (kind)
			tssm_pkg::REQ_PUSH_LOW: begin
				if (low_count + high_count < tssm_pkg::DEPTH) begin
					stored_words[low_count] = value;
					low_count++;
				end else begin
					ans.code = tssm_pkg::ST_OVERFLOW;
				end
			end
			tssm_pkg::REQ_PUSH_HIGH: begin
				if (low_count + high_count < tssm_pkg::DEPTH) begin
					high_count++;
					stored_words[tssm_pkg::DEPTH - high_count] = value;
				end else begin
					ans.code = tssm_pkg::ST_OVERFLOW;
				end
			end
			tssm_pkg::REQ_POP_LOW: begin
				if (low_count > 0) begin
					low_count--;
					ans.word = stored_words[low_count];
				end else begin
					ans.word = '1;
					ans.code = tssm_pkg::ST_UNDERFLOW;
				end
			end
			default: begin
				if (high_count > 0) begin
					ans.word = stored_words[tssm_pkg::DEPTH - high_count];
					high_count--;
				end else begin
					ans.word = '1;
					ans.code = tssm_pkg::ST_UNDERFLOW;
				end
			end
		endcase
		return ans;
	endfunction

	task automatic send_request(input logic [1:0] kind,
			input logic [tssm_pkg::WORD_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.req_type   <= kind;
		req_ch.push_value <= value;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
		pending_answers.push_back(predict_answer(kind, value));
	endtask

	// hold the request side quiet until every answer is back
	task automatic wait_for_answers();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_pops();
		send_request(tssm_pkg::REQ_POP_LOW, 32'h1234_5678);
		send_request(tssm_pkg::REQ_POP_HIGH, 32'hFFFF_FFFF);
	endtask

	task automatic test_word_extremes();
		send_request(tssm_pkg::REQ_PUSH_LOW, 32'h7FFF_FFFF);
		send_request(tssm_pkg::REQ_PUSH_HIGH, 32'h8000_0000);
		send_request(tssm_pkg::REQ_POP_HIGH, '0);
		send_request(tssm_pkg::REQ_POP_LOW, '0);
	endtask

	// stack one takes all but the top word, stack two takes the last one
	task automatic test_full_memory();
		for (int i = 0; i < tssm_pkg::DEPTH - 1; i++)
			send_request(tssm_pkg::REQ_PUSH_LOW, $urandom());
		send_request(tssm_pkg::REQ_PUSH_HIGH, $urandom());
		send_request(tssm_pkg::REQ_PUSH_LOW, 32'hFFFF_FFFF);
		send_request(tssm_pkg::REQ_PUSH_HIGH, 32'h0000_0000);
	endtask

	task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
			input int unsigned stall_pct);
		int unsigned                 burst_left;
		int unsigned                 push_pct;
		int unsigned                 side_bias;
		bit                          is_pop;
		bit                          high_side;
		logic [1:0]                  kind;
		logic [tssm_pkg::WORD_W-1:0] value;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		burst_left = 0;
		push_pct = 50;
		side_bias = 2;
		for (int n = 0; n < items; n++) begin
			if (n == items / 2)
				wait_for_answers();
			// bursts lean toward filling or draining so both full and empty are hit
			if (burst_left == 0) begin
				burst_left = $urandom_range(40, 5);
				case ($urandom_range(2))
					0: push_pct = 85;
					1: push_pct = 15;
					default: push_pct = 50;
				endcase
				side_bias = $urandom_range(2);
			end
			burst_left--;
			is_pop = ($urandom_range(99) >= push_pct);
			high_side = (side_bias == 2) ? 1'($urandom_range(1)) : side_bias[0];
			if (is_pop)
				kind = high_side ? tssm_pkg::REQ_POP_HIGH : tssm_pkg::REQ_POP_LOW;
			else
				kind = high_side ? tssm_pkg::REQ_PUSH_HIGH : tssm_pkg::REQ_PUSH_LOW;
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(4))
					0: value = 32'h0000_0000;
					1: value = 32'h0000_0001;
					2: value = 32'hFFFF_FFFF;
					3: value = 32'h7FFF_FFFF;
					default: value = 32'h8000_0000;
				endcase
			end else begin
				value = $urandom();
			end
			send_request(kind, value);
		end
	endtask

	// result checker, also drives the receiver stall
	initial begin
		stack_answer_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				if (pending_answers.size() == 0) begin
					$error("result with no pending request: pop_value %0d status %0d",
						rsp_ch.pop_value, rsp_ch.status);
					fail_count++;
				end else begin
					want = pending_answers.pop_front();
					if (rsp_ch.pop_value !== want.word) begin
						$error("pop_value: expected %0d, got %0d", $signed(want.word),
							rsp_ch.pop_value);
						fail_count++;
					end
					if (rsp_ch.status !== want.code) begin
						$error("status: expected %0d, got %0d", want.code, rsp_ch.status);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		fail_count    = 0;
		low_count     = 0;
		high_count    = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		arst_n            <= 1'b0;
		req_ch.valid      <= 1'b0;
		req_ch.req_type   <= tssm_pkg::REQ_PUSH_LOW;
		req_ch.push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_pops();
		test_word_extremes();
		test_full_memory();
		wait_for_answers();

		test_random_traffic(TRAFFIC_ITEMS, 0, 0);
		wait_for_answers();
		test_random_traffic(TRAFFIC_ITEMS, 88, 0);
		wait_for_answers();
		test_random_traffic(TRAFFIC_ITEMS, 0, 88);
		wait_for_answers();
		test_random_traffic(TRAFFIC_ITEMS, 36, 36);

		wait_for_answers();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
